// File: hw/rtl/zero_block_ratio_unit_defines.svh
// Assertion macros for the small-tile ratio unit.
// Used by the controller and the divider; expects clk and arst_n in scope.
`ifndef ZERO_BLOCK_RATIO_UNIT_DEFINES_SVH
`define ZERO_BLOCK_RATIO_UNIT_DEFINES_SVH

// Checked outside reset only
`define ZBR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included
`define ZBR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/zbr_pkg.sv
// Shared widths, command and status types of the small-tile ratio unit.
// No dependencies.
package zbr_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SIZE_W     = 12;
	localparam int THRESH_W   = 16;
	localparam int COUNT_W    = 23;
	localparam int RATIO_W    = 17;
	localparam int FRAC_W     = 16;
	localparam int STEP_W     = $clog2(FRAC_W);
	localparam int AREA_W     = 2 * SIZE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Controller to datapath
	typedef struct packed {
		logic load;       // sample transfer, read the tile column store
		logic update;     // read-modify-write of the store, advance position
		logic div_load;   // capture the frame total
		logic div_area;   // width times height
		logic div_check;  // saturation compare, set up the remainder
		logic div_step;   // one restoring step
		logic out_load;   // move the result into the output register
	} zbr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic frame_end;
		logic last_step;
		logic out_busy;
	} zbr_status_t;

endpackage

// File: hw/rtl/zbr_ctrl.sv
// Controller of the small-tile ratio unit: sequences sample updates and the
// frame-end division. Depends on zbr_pkg and zero_block_ratio_unit_defines.svh.
`include "zero_block_ratio_unit_defines.svh"

module zbr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  zbr_pkg::zbr_status_t status,
	output zbr_pkg::zbr_cmd_t    cmd
);
	import zbr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UPD   = 3'd1;
	localparam logic [2:0] S_AREA  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				if (status.frame_end) begin
					cmd.div_load = 1'b1;
					state_d      = S_AREA;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_AREA: begin
				cmd.div_area = 1'b1;
				state_d      = S_CHECK;
			end
			S_CHECK: begin
				cmd.div_check = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.last_step) state_d = S_OUT;
			end
			S_OUT: begin
				// wait for the previous result to leave
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	`ZBR_ASSERT(a_transfer_updates, sample_valid && sample_ready |=> cmd.update,
		"sample transfer not followed by a store update")
	`ZBR_ASSERT_RST(a_reset_idle, !arst_n |-> state_q == S_IDLE,
		"controller not idle in reset")

endmodule

// File: hw/rtl/zbr_tile.sv
// Tile path: configuration registers, raster position, tile column store and
// running total of samples in qualifying tiles. Depends on zbr_pkg.
module zbr_tile #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int TILE_SIZE  = 16,
	localparam int TOTAL_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [zbr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [zbr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [zbr_pkg::SAMPLE_W-1:0]  sample,
	input  zbr_pkg::zbr_cmd_t                    cmd,
	output logic                                 frame_end,
	output logic [TOTAL_W-1:0]                   total_next,
	output logic [zbr_pkg::SIZE_W-1:0]           frame_width,
	output logic [zbr_pkg::SIZE_W-1:0]           frame_height
);
	import zbr_pkg::*;

	localparam int TILE_COLS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
	localparam int TCW       = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
	localparam int CITW      = $clog2(TILE_SIZE);
	localparam int TSW       = $clog2(TILE_SIZE * TILE_SIZE + 1);
	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int RW        = $clog2(MAX_HEIGHT);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_THRESHOLD = 2'd2;

	localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 12'd16;
	localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 12'd16;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1;
	localparam logic [CITW-1:0]     TILE_LAST    = CITW'(TILE_SIZE - 1);

	// zero reads as one, above the maximum saturates
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input int maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0)              r = SIZE_W'(1);
		else if (32'(v) > maxv)   r = SIZE_W'(maxv);
		else                      r = v;
		return r;
	endfunction

	logic [SIZE_W-1:0]   fw_q, fh_q;
	logic [THRESH_W-1:0] thr_q;

	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic [CITW-1:0]     cit_q, rit_q;
	logic [TCW-1:0]      tc_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [TSW:0]           mem_q [TILE_COLS];
	logic [TILE_COLS-1:0]   vld_q;
	logic [TSW:0]           rd_s1;
	logic                   vld_s1;
	logic [SAMPLE_W-1:0]    sample_s1;

	logic [SAMPLE_W:0] mag;
	logic              small_hit, row_end, last_row, tile_right, tile_bottom;
	logic              tile_fresh, cur_all, new_all, add_tile;
	logic [TSW-1:0]    cur_cnt, new_cnt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= WIDTH_RESET;
			fh_q  <= HEIGHT_RESET;
			thr_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:     fw_q  <= clamp_size(cfg_data[SIZE_W-1:0], MAX_WIDTH);
				REG_FRAME_HEIGHT:    fh_q  <= clamp_size(cfg_data[SIZE_W-1:0], MAX_HEIGHT);
				REG_SMALL_THRESHOLD: thr_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	assign frame_width  = fw_q;
	assign frame_height = fh_q;

	// Store read on sample transfer, registered
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_s1 <= sample;
			rd_s1     <= mem_q[tc_q];
			vld_s1    <= vld_q[tc_q];
		end
		if (cmd.update) mem_q[tc_q] <= {new_all, new_cnt};
	end

	// Entry valid bits: an unwritten entry reads as all small, zero samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         vld_q        <= '0;
		else if (cmd.update) vld_q[tc_q]  <= 1'b1;
	end

	// Magnitude, -32768 gives 32768
	assign mag       = sample_s1[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1 << SAMPLE_W)
		- {1'b0, sample_s1}) : {1'b0, sample_s1};
	assign small_hit = mag < {1'b0, thr_q};

	assign row_end     = (32'(col_q) + 32'd1) >= 32'(fw_q);
	assign last_row    = (32'(row_q) + 32'd1) >= 32'(fh_q);
	assign tile_right  = row_end || (cit_q == TILE_LAST);
	assign tile_bottom = last_row || (rit_q == TILE_LAST);
	assign frame_end   = row_end && last_row;

	// Tile column update; first sample of a tile starts it afresh
	assign tile_fresh = (cit_q == '0 && rit_q == '0) || !vld_s1;
	assign cur_all    = tile_fresh ? 1'b1 : rd_s1[TSW];
	assign cur_cnt    = tile_fresh ? '0 : rd_s1[TSW-1:0];
	assign new_all    = cur_all && small_hit;
	assign new_cnt    = cur_cnt + TSW'(1);
	assign add_tile   = tile_right && tile_bottom && new_all;
	assign total_next = total_q + (add_tile ? TOTAL_W'(new_cnt) : '0);

	// Raster position and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			cit_q   <= '0;
			rit_q   <= '0;
			tc_q    <= '0;
			total_q <= '0;
		end else if (cmd.update) begin
			if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				cit_q   <= '0;
				rit_q   <= '0;
				tc_q    <= '0;
				total_q <= '0;
			end else if (row_end) begin
				col_q   <= '0;
				cit_q   <= '0;
				tc_q    <= '0;
				row_q   <= row_q + RW'(1);
				rit_q   <= (rit_q == TILE_LAST) ? '0 : rit_q + CITW'(1);
				total_q <= total_next;
			end else begin
				col_q   <= col_q + CW'(1);
				total_q <= total_next;
				if (cit_q == TILE_LAST) begin
					cit_q <= '0;
					tc_q  <= tc_q + TCW'(1);
				end else begin
					cit_q <= cit_q + CITW'(1);
				end
			end
		end
	end

endmodule

// File: hw/rtl/zbr_div.sv
// Frame-end arithmetic: area multiply, saturation check, restoring fraction
// division and the output register. Depends on zbr_pkg and the defines header.
`include "zero_block_ratio_unit_defines.svh"

module zbr_div #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	localparam int TOTAL_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  zbr_pkg::zbr_cmd_t              cmd,
	input  logic [TOTAL_W-1:0]             total,
	input  logic [zbr_pkg::SIZE_W-1:0]     frame_width,
	input  logic [zbr_pkg::SIZE_W-1:0]     frame_height,
	input  logic                           result_ready,
	output logic                           result_valid,
	output logic [zbr_pkg::COUNT_W-1:0]    small_sample_count,
	output logic [zbr_pkg::RATIO_W-1:0]    small_ratio,
	output logic                           last_step,
	output logic                           out_busy
);
	import zbr_pkg::*;

	localparam int DW = ((TOTAL_W > AREA_W) ? TOTAL_W : AREA_W) + 1;
	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << FRAC_W);

	logic [TOTAL_W-1:0] num_q;
	logic [AREA_W-1:0]  area_q;
	logic               sat_q;
	logic [DW-1:0]      rem_q, rem_sh;
	logic [FRAC_W-1:0]  quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               valid_q;
	logic               ge;

	assign rem_sh    = {rem_q[DW-2:0], 1'b0};
	assign ge        = rem_sh >= DW'(area_q);
	assign last_step = step_q == STEP_W'(FRAC_W - 1);

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.div_load) num_q <= total;
		if (cmd.div_area) area_q <= AREA_W'(frame_width * frame_height);
		if (cmd.div_check) begin
			sat_q  <= DW'(num_q) >= DW'(area_q);
			rem_q  <= DW'(num_q);
			quo_q  <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			// one quotient bit a cycle, most significant first
			rem_q  <= ge ? rem_sh - DW'(area_q) : rem_sh;
			quo_q  <= {quo_q[FRAC_W-2:0], ge};
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.out_load) begin
			small_sample_count <= COUNT_W'(num_q);
			small_ratio        <= sat_q ? RATIO_ONE : RATIO_W'(quo_q);
		end
	end

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           valid_q <= 1'b0;
		else if (cmd.out_load) valid_q <= 1'b1;
		else if (result_ready) valid_q <= 1'b0;
	end

	assign result_valid = valid_q;
	assign out_busy     = valid_q && !result_ready;

	`ZBR_ASSERT(a_no_overwrite, cmd.out_load |-> !valid_q || result_ready,
		"result overwritten before transfer")
	`ZBR_ASSERT(a_ratio_bound, valid_q |-> small_ratio <= RATIO_ONE,
		"ratio above one")

endmodule

// File: hw/rtl/zero_block_ratio_unit.sv
// Top level of the small-tile ratio unit.
// Depends on zbr_pkg, zbr_ctrl, zbr_tile and zbr_div.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//  sample   | sample_valid / sample_ready| sample
//  result   | result_valid / result_ready| small_sample_count, small_ratio
//
// Each sample reads the tile column store, then does its read-modify-write;
// no new sample is taken before that. The last sample of a frame adds the
// area multiply, saturation compare, 16 restoring division steps and output
// load, plus any wait for the output register to empty. The store's entries
// carry valid bits that reset clears, so there is no clearing pass. cfg_ready
// is always high; a waiting result holds up only the next frame's end.
module zero_block_ratio_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int TILE_SIZE  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [zbr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [zbr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic signed [zbr_pkg::SAMPLE_W-1:0]  sample,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [zbr_pkg::COUNT_W-1:0]          small_sample_count,
	output logic [zbr_pkg::RATIO_W-1:0]          small_ratio
);
	import zbr_pkg::*;

	localparam int TOTAL_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	zbr_cmd_t           cmd;
	zbr_status_t        status;
	logic [TOTAL_W-1:0] total_next;
	logic [SIZE_W-1:0]  frame_width, frame_height;
	logic               frame_end, last_step, out_busy;

	assign cfg_ready = 1'b1;

	assign status.frame_end = frame_end;
	assign status.last_step = last_step;
	assign status.out_busy  = out_busy;

	zbr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.status       (status),
		.cmd          (cmd)
	);

	zbr_tile #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.TILE_SIZE  (TILE_SIZE)
	) u_tile (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.cmd          (cmd),
		.frame_end    (frame_end),
		.total_next   (total_next),
		.frame_width  (frame_width),
		.frame_height (frame_height)
	);

	zbr_div #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_div (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.total              (total_next),
		.frame_width        (frame_width),
		.frame_height       (frame_height),
		.result_ready       (result_ready),
		.result_valid       (result_valid),
		.small_sample_count (small_sample_count),
		.small_ratio        (small_ratio),
		.last_step          (last_step),
		.out_busy           (out_busy)
	);

endmodule
